// ===== hw/rtl/esmg_pkg.sv =====
// Shared types and constants for the eased servo motion generator.
package esmg_pkg;

    localparam int POS_W       = 8;
    localparam int STEP_W      = 8;
    localparam int GAIN_W      = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_IDX_W   = 1;
    localparam int FRAC_W      = 16;               // Q0.16 ratio and ease value
    localparam int GAIN_FRAC_W = 12;               // Q4.12 gain
    localparam int CAL_PROD_W  = POS_W + GAIN_W;
    localparam int DIV_CNT_W   = 4;                // counts FRAC_W quotient bits
    localparam int TSQ_W       = 2 * FRAC_W;
    localparam int CUBE_F_W    = FRAC_W + 2;       // 3.0 - 2t in Q2.16
    localparam int CUBE_P_W    = TSQ_W + CUBE_F_W;
    localparam int OFF_P_W     = POS_W + FRAC_W + 1;
    localparam int OFF_W       = OFF_P_W - FRAC_W;
    localparam int SPOS_W      = POS_W + 2;

    localparam logic [GAIN_W-1:0]   CAL_GAIN_RST     = 16'd4096;
    localparam logic [STEP_W-1:0]   MOTION_STEPS_RST = 8'd50;
    localparam logic [CUBE_F_W-1:0] THREE_Q16        = 18'd196608;
    localparam logic [OFF_P_W-1:0]  ROUND_HALF_Q16   = 25'd32768;
    localparam logic [POS_W-1:0]    POS_MAX          = 8'd255;

    localparam logic [CFG_IDX_W-1:0] CFG_CAL_GAIN     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MOTION_STEPS = 1'd1;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_SET  = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;          // capture the accepted request
        logic cal_mul;       // form desired * gain
        logic set_desired;   // store a new desired position
        logic try_start;     // start a move if the target differs
        logic finish_move;   // land on target and end the move
        logic div_init;      // seed the step / steps divider
        logic div_step;      // one quotient bit
        logic mul_tsq;       // t * t
        logic mul_cube;      // t^2 * (3 - 2t)
        logic mul_off;       // |distance| * s + half
        logic advance;       // commit eased position and step
        logic emit;          // load the result register
    } esmg_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic item_set;
        logic in_motion;
        logic last_step;
        logic div_last;
        logic out_free;
    } esmg_stat_t;

endpackage

// ===== hw/rtl/esmg_ctrl.sv =====
// Controller state machine: sequences decode, division, multiplies and result hand-off.
module esmg_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  esmg_pkg::esmg_stat_t stat,
    output esmg_pkg::esmg_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_START,
        S_DIV,
        S_MUL_TSQ,
        S_MUL_CUBE,
        S_MUL_OFF,
        S_POS,
        S_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   s_ready_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                cmd.cal_mul = 1'b1;
                if (stat.item_set) begin
                    cmd.set_desired = 1'b1;
                    state_next      = S_EMIT;
                end else if (!stat.in_motion) begin
                    state_next = S_START;
                end else if (stat.last_step) begin
                    cmd.finish_move = 1'b1;
                    state_next      = S_EMIT;
                end else begin
                    cmd.div_init = 1'b1;
                    state_next   = S_DIV;
                end
            end
            S_START: begin
                cmd.try_start = 1'b1;
                state_next    = S_EMIT;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_last) begin
                    state_next = S_MUL_TSQ;
                end
            end
            S_MUL_TSQ: begin
                cmd.mul_tsq = 1'b1;
                state_next  = S_MUL_CUBE;
            end
            S_MUL_CUBE: begin
                cmd.mul_cube = 1'b1;
                state_next   = S_MUL_OFF;
            end
            S_MUL_OFF: begin
                cmd.mul_off = 1'b1;
                state_next  = S_POS;
            end
            S_POS: begin
                cmd.advance = 1'b1;
                state_next  = S_EMIT;
            end
            S_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            s_ready_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            s_ready_reg <= (state_next == S_IDLE);
        end
    end

    assign s_ready = s_ready_reg;

endmodule

// ===== hw/rtl/esmg_dp.sv =====
// Datapath: axis state, configuration, divider, ease multiplies and result register.
module esmg_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  esmg_pkg::esmg_cmd_t                 cmd,
    output esmg_pkg::esmg_stat_t                stat,
    input  logic                                s_command,
    input  logic [esmg_pkg::POS_W-1:0]          s_target_position,
    input  logic                                cfg_we,
    input  logic [esmg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [esmg_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [esmg_pkg::POS_W-1:0]          m_position,
    output logic                                m_moving,
    output logic                                m_move_done
);

    logic [esmg_pkg::GAIN_W-1:0]     cal_gain_reg;
    logic [esmg_pkg::STEP_W-1:0]     motion_steps_reg;

    logic                            item_cmd_reg;
    logic [esmg_pkg::POS_W-1:0]      item_pos_reg;

    logic [esmg_pkg::POS_W-1:0]      desired_reg;
    logic [esmg_pkg::POS_W-1:0]      current_reg;
    logic [esmg_pkg::POS_W-1:0]      start_reg;
    logic [esmg_pkg::POS_W-1:0]      end_reg;
    logic [esmg_pkg::STEP_W-1:0]     step_reg;
    logic                            in_motion_reg;
    logic                            done_reg;

    logic [esmg_pkg::CAL_PROD_W-1:0] cal_prod_reg;
    logic [esmg_pkg::POS_W-1:0]      cal_target;

    logic [esmg_pkg::STEP_W-1:0]     rem_reg;
    logic [esmg_pkg::FRAC_W-1:0]     quot_reg;
    logic [esmg_pkg::DIV_CNT_W-1:0]  div_cnt_reg;
    logic [esmg_pkg::STEP_W:0]       rem_shift;
    logic                            rem_ge;

    logic [esmg_pkg::TSQ_W-1:0]      tsq_reg;
    logic [esmg_pkg::CUBE_F_W-1:0]   cube_f_reg;
    logic [esmg_pkg::CUBE_P_W-1:0]   cube_prod;
    logic [esmg_pkg::FRAC_W-1:0]     ease_reg;
    logic [esmg_pkg::POS_W+esmg_pkg::FRAC_W-1:0] off_mul;
    logic [esmg_pkg::OFF_P_W-1:0]    off_prod_reg;

    logic [esmg_pkg::STEP_W:0]       step_next;
    logic                            dist_neg;
    logic [esmg_pkg::POS_W-1:0]      dist_mag;
    logic [esmg_pkg::OFF_W-1:0]      offset;
    logic signed [esmg_pkg::SPOS_W-1:0] pos_sum;
    logic [esmg_pkg::POS_W-1:0]      pos_clamped;

    logic                            m_valid_reg;
    logic [esmg_pkg::POS_W-1:0]      m_position_reg;
    logic                            m_moving_reg;
    logic                            m_move_done_reg;

    // Calibrated target: truncate Q4.12 product, saturate to full scale.
    always_comb begin
        if (cal_prod_reg[esmg_pkg::CAL_PROD_W-1:esmg_pkg::GAIN_FRAC_W+esmg_pkg::POS_W] != '0) begin
            cal_target = esmg_pkg::POS_MAX;
        end else begin
            cal_target = cal_prod_reg[esmg_pkg::GAIN_FRAC_W +: esmg_pkg::POS_W];
        end
    end

    assign step_next = {1'b0, step_reg} + {{esmg_pkg::STEP_W{1'b0}}, 1'b1};

    // Restoring divider: low dividend bits are zero, so shift in zeros.
    assign rem_shift = {rem_reg, 1'b0};
    assign rem_ge    = (rem_shift >= {1'b0, motion_steps_reg});

    assign cube_prod = tsq_reg * cube_f_reg;

    assign dist_neg = (end_reg < start_reg);
    assign dist_mag = dist_neg ? (start_reg - end_reg) : (end_reg - start_reg);
    assign off_mul  = dist_mag * ease_reg;
    assign offset   = off_prod_reg[esmg_pkg::OFF_P_W-1:esmg_pkg::FRAC_W];

    always_comb begin
        if (dist_neg) begin
            pos_sum = $signed({2'b00, start_reg}) - $signed({1'b0, offset});
        end else begin
            pos_sum = $signed({2'b00, start_reg}) + $signed({1'b0, offset});
        end
        if (pos_sum < 0) begin
            pos_clamped = '0;
        end else if (pos_sum > $signed({2'b00, esmg_pkg::POS_MAX})) begin
            pos_clamped = esmg_pkg::POS_MAX;
        end else begin
            pos_clamped = pos_sum[esmg_pkg::POS_W-1:0];
        end
    end

    always_comb begin
        stat.item_set  = (item_cmd_reg == esmg_pkg::CMD_SET);
        stat.in_motion = in_motion_reg;
        stat.last_step = (step_next >= {1'b0, motion_steps_reg});
        stat.div_last  = (div_cnt_reg == {esmg_pkg::DIV_CNT_W{1'b1}});
        stat.out_free  = !m_valid_reg || m_ready;
    end

    // Control state and configuration.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_gain_reg     <= esmg_pkg::CAL_GAIN_RST;
            motion_steps_reg <= esmg_pkg::MOTION_STEPS_RST;
            desired_reg      <= '0;
            current_reg      <= '0;
            start_reg        <= '0;
            end_reg          <= '0;
            step_reg         <= '0;
            in_motion_reg    <= 1'b0;
            done_reg         <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    esmg_pkg::CFG_CAL_GAIN:     cal_gain_reg <= cfg_wdata;
                    esmg_pkg::CFG_MOTION_STEPS: motion_steps_reg <= cfg_wdata[esmg_pkg::STEP_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.load) begin
                done_reg <= 1'b0;
            end
            if (cmd.set_desired) begin
                desired_reg <= item_pos_reg;
            end
            if (cmd.try_start && (cal_target != current_reg)) begin
                start_reg     <= current_reg;
                end_reg       <= cal_target;
                step_reg      <= '0;
                in_motion_reg <= 1'b1;
            end
            if (cmd.finish_move) begin
                current_reg   <= end_reg;
                step_reg      <= '0;
                in_motion_reg <= 1'b0;
                done_reg      <= 1'b1;
            end
            if (cmd.advance) begin
                current_reg <= pos_clamped;
                step_reg    <= step_next[esmg_pkg::STEP_W-1:0];
            end
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            item_cmd_reg <= s_command;
            item_pos_reg <= s_target_position;
        end
        if (cmd.cal_mul) begin
            cal_prod_reg <= desired_reg * cal_gain_reg;
        end
        if (cmd.div_init) begin
            rem_reg     <= step_next[esmg_pkg::STEP_W-1:0];
            quot_reg    <= '0;
            div_cnt_reg <= '0;
        end else if (cmd.div_step) begin
            rem_reg     <= rem_ge ? (rem_shift[esmg_pkg::STEP_W-1:0]
                                     - motion_steps_reg)
                                  : rem_shift[esmg_pkg::STEP_W-1:0];
            quot_reg    <= {quot_reg[esmg_pkg::FRAC_W-2:0], rem_ge};
            div_cnt_reg <= div_cnt_reg + 1'b1;
        end
        if (cmd.mul_tsq) begin
            tsq_reg    <= quot_reg * quot_reg;
            cube_f_reg <= esmg_pkg::THREE_Q16 - {1'b0, quot_reg, 1'b0};
        end
        if (cmd.mul_cube) begin
            ease_reg <= cube_prod[esmg_pkg::TSQ_W +: esmg_pkg::FRAC_W];
        end
        if (cmd.mul_off) begin
            off_prod_reg <= {{esmg_pkg::OFF_P_W-esmg_pkg::POS_W-esmg_pkg::FRAC_W{1'b0}},
                             off_mul} + esmg_pkg::ROUND_HALF_Q16;
        end
        if (cmd.emit) begin
            m_position_reg  <= cmd.finish_move ? end_reg : current_reg;
            m_moving_reg    <= in_motion_reg;
            m_move_done_reg <= done_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_position  = m_position_reg;
    assign m_moving    = m_moving_reg;
    assign m_move_done = m_move_done_reg;

endmodule

// ===== hw/rtl/eased_servo_motion_generator_top.sv =====
// Top level of the eased servo motion generator: controller plus datapath.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------------------
//  s_       | s_valid / s_ready  | s_command, s_target_position
//  m_       | m_valid / m_ready  | m_position, m_moving, m_move_done
//  cfg_     | cfg_we (no wait)   | cfg_index, cfg_wdata
//
// A set request or a tick that ends a move goes from decode straight to emit,
// an idle tick passes through the start state first; a tick that advances a move
// also runs the bit-serial step/steps divider followed by three registered
// multiplies. s_ready rises together with m_valid when the result is loaded.
// One request is in work at a time; a finished result waits in the output
// register while the next request is accepted, and a stalled m_ready holds
// the next result (and s_ready) until the register frees up.
// Reset (aresetn low, synchronous) idles the axis, zeroes the axis positions,
// holds s_ready low and restores cal_gain to 1.0 and motion_steps to 50.
module eased_servo_motion_generator_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_command,
    input  logic [esmg_pkg::POS_W-1:0]      s_target_position,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [esmg_pkg::POS_W-1:0]      m_position,
    output logic                            m_moving,
    output logic                            m_move_done,
    input  logic                            cfg_we,
    input  logic [esmg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [esmg_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    // Command and status link between controller and datapath.
    esmg_pkg::esmg_cmd_t  cmd;
    esmg_pkg::esmg_stat_t stat;

    // Sequence each request: decode, optional divide and multiplies, emit.
    esmg_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Hold axis state, configuration, arithmetic and the result register.
    esmg_dp u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .stat              (stat),
        .s_command         (s_command),
        .s_target_position (s_target_position),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_position        (m_position),
        .m_moving          (m_moving),
        .m_move_done       (m_move_done)
    );

endmodule

// ===== hw/rtl/esmg_chk.sv =====
// Port-level checker for the eased servo motion generator, bound to the top level.
module esmg_chk (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_valid,
    input logic                            s_ready,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic [esmg_pkg::POS_W-1:0]      m_position,
    input logic                            m_moving,
    input logic                            m_move_done
);

    logic [1:0] pend_reg;
    logic       s_acc;
    logic       m_acc;

    assign s_acc = s_valid && s_ready;
    assign m_acc = m_valid && m_ready;

    // Requests accepted but not yet delivered.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else begin
            pend_reg <= pend_reg + {1'b0, s_acc} - {1'b0, m_acc};
        end
    end

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_position)
                               && $stable(m_moving) && $stable(m_move_done))
        else $error("result changed while stalled");

    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_move_done |-> !m_moving)
        else $error("move_done with moving still set");

    a_one_in_work: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc |=> !s_ready)
        else $error("request accepted while another is in work");

    a_no_extra: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> pend_reg != 2'd0)
        else $error("result with no pending request");

    a_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg != 2'd3)
        else $error("too many pending requests");

endmodule

bind eased_servo_motion_generator_top esmg_chk u_esmg_chk (.*);

// ===== verif/tb_eased_servo_motion_generator_top.sv =====
// Self-checking testbench for the eased servo motion generator top level.
module tb_eased_servo_motion_generator_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [esmg_pkg::POS_W-1:0]  pos_t;
    typedef logic [esmg_pkg::GAIN_W-1:0] gain_t;
    typedef logic [esmg_pkg::STEP_W-1:0] steps_t;

    // Servo output as the axis should drive it after one request.
    typedef struct {
        pos_t position;
        logic moving;
        logic move_done;
    } servo_out_t;

    // Receiver stall patterns, switched at random intervals.
    typedef enum int unsigned {
        RDY_ALWAYS,
        RDY_MOSTLY,
        RDY_RARELY,
        RDY_PERIODIC
    } ready_mode_t;

    localparam int unsigned RANDOM_REQUESTS = 950;
    localparam int unsigned HOLD_OFF_CYCLES = 300;
    localparam int unsigned SETTLE_CYCLES   = 40;

    logic                                aclk              = 1'b0;
    logic                                aresetn           = 1'b0;
    logic                                s_valid           = 1'b0;
    logic                                s_ready;
    logic                                s_command         = esmg_pkg::CMD_TICK;
    pos_t                                s_target_position = '0;
    logic                                m_valid;
    logic                                m_ready           = 1'b0;
    pos_t                                m_position;
    logic                                m_moving;
    logic                                m_move_done;
    logic                                cfg_we            = 1'b0;
    logic [esmg_pkg::CFG_IDX_W-1:0]      cfg_index         = esmg_pkg::CFG_CAL_GAIN;
    logic [esmg_pkg::CFG_DATA_W-1:0]     cfg_wdata         = '0;

    // Axis model: register copies and motion state.
    gain_t  ax_gain;
    steps_t ax_steps;
    pos_t   ax_desired;
    pos_t   ax_current;
    pos_t   ax_start;
    pos_t   ax_end;
    steps_t ax_step;
    logic   ax_moving;

    servo_out_t servo_out_q[$];

    int unsigned requests_sent = 0;
    int unsigned error_count   = 0;
    int unsigned burst_left    = 0;
    int unsigned hold_req      = 0;

    eased_servo_motion_generator_top dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_command         (s_command),
        .s_target_position (s_target_position),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_position        (m_position),
        .m_moving          (m_moving),
        .m_move_done       (m_move_done),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata)
    );

    // 10 ns clock.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Calibrated target: desired * gain in Q4.12, truncated, saturated at full scale.
    function automatic pos_t calibrated_target(input pos_t desired, input gain_t gain);
        int unsigned scaled;
        scaled = (int'(desired) * int'(gain)) >> esmg_pkg::GAIN_FRAC_W;
        return (scaled > 255) ? esmg_pkg::POS_MAX : scaled[esmg_pkg::POS_W-1:0];
    endfunction

    // Smoothstep position for step k of n, ratio and ease in Q0.16, rounded half away from zero.
    function automatic pos_t eased_position(input int unsigned k,
                                            input int unsigned n,
                                            input pos_t from,
                                            input pos_t to);
        longint unsigned ratio, ease, span, offset;
        int              pos;
        ratio  = (longint'(k) << esmg_pkg::FRAC_W) / longint'(n);
        ease   = (ratio * ratio * (longint'(3) * 65536 - 2 * ratio)) >> 32;
        span   = (from > to) ? longint'(from - to) : longint'(to - from);
        offset = (span * ease + 32768) >> esmg_pkg::FRAC_W;
        pos    = int'(from);
        if (to < from) begin
            pos = pos - int'(offset);
        end else begin
            pos = pos + int'(offset);
        end
        if (pos < 0) begin
            pos = 0;
        end
        if (pos > 255) begin
            pos = 255;
        end
        return pos[esmg_pkg::POS_W-1:0];
    endfunction

    // Advance the axis model by one accepted request and queue the servo output it drives.
    task automatic advance_axis_model(input logic cmd, input pos_t pos);
        servo_out_t  out;
        pos_t        target;
        int unsigned next_step;
        out.move_done = 1'b0;
        if (cmd == esmg_pkg::CMD_SET) begin
            ax_desired = pos;
        end else if (!ax_moving) begin
            target = calibrated_target(ax_desired, ax_gain);
            if (target != ax_current) begin
                ax_start  = ax_current;
                ax_end    = target;
                ax_step   = '0;
                ax_moving = 1'b1;
            end
        end else begin
            next_step = int'(ax_step) + 1;
            if (next_step >= int'(ax_steps)) begin
                ax_current    = ax_end;
                ax_step       = '0;
                ax_moving     = 1'b0;
                out.move_done = 1'b1;
            end else begin
                ax_step    = next_step[esmg_pkg::STEP_W-1:0];
                ax_current = eased_position(next_step, int'(ax_steps), ax_start, ax_end);
            end
        end
        out.position = ax_current;
        out.moving   = ax_moving;
        servo_out_q.push_back(out);
    endtask

    // Offer one request and hold it until accepted; valid is left high.
    task automatic send_request(input logic cmd, input pos_t pos);
        s_valid           <= 1'b1;
        s_command         <= cmd;
        s_target_position <= pos;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        advance_axis_model(cmd, pos);
        requests_sent++;
    endtask

    // Insert a random gap at the end of each burst; some bursts run back to back.
    task automatic sender_pace();
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
    endtask

    // Drop valid and wait until every queued servo output has been checked.
    task automatic wait_for_outputs();
        s_valid <= 1'b0;
        while (servo_out_q.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    // Write one register while the block is idle and mirror it in the model.
    task automatic write_reg(input logic [esmg_pkg::CFG_IDX_W-1:0]  idx,
                             input logic [esmg_pkg::CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        if (idx == esmg_pkg::CFG_CAL_GAIN) begin
            ax_gain = data;
        end else begin
            ax_steps = data[esmg_pkg::STEP_W-1:0];
        end
    endtask

    // Compare one accepted servo output with the oldest prediction.
    task automatic check_servo_output();
        servo_out_t exp_out;
        if (servo_out_q.size() == 0) begin
            $error("servo output with nothing predicted: position %0d", m_position);
            error_count++;
        end else begin
            exp_out = servo_out_q.pop_front();
            if (m_position !== exp_out.position) begin
                $error("position: expected %0d, got %0d", exp_out.position, m_position);
                error_count++;
            end
            if (m_moving !== exp_out.moving) begin
                $error("moving: expected %0d, got %0d", exp_out.moving, m_moving);
                error_count++;
            end
            if (m_move_done !== exp_out.move_done) begin
                $error("move_done: expected %0d, got %0d", exp_out.move_done, m_move_done);
                error_count++;
            end
        end
    endtask

    // Check every result the moment it is taken.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            check_servo_output();
        end
    end

    // Receiver stall pattern, plus a long hold-off on request from the stimulus.
    ready_mode_t ready_mode = RDY_ALWAYS;
    int unsigned mode_left  = 0;
    int unsigned hold_left  = 0;
    int unsigned hold_seen  = 0;

    always @(posedge aclk) begin
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_OFF_CYCLES;
        end
        // pick a new pattern when the current one runs out
        if (mode_left == 0) begin
            ready_mode = ready_mode_t'($urandom_range(0, 3));
            mode_left  = $urandom_range(8, 80);
        end else begin
            mode_left--;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            case (ready_mode)
                RDY_ALWAYS: begin
                    m_ready <= 1'b1;
                end
                RDY_MOSTLY: begin
                    m_ready <= ($urandom_range(0, 3) != 0);
                end
                RDY_RARELY: begin
                    m_ready <= ($urandom_range(0, 3) == 0);
                end
                default: begin
                    m_ready <= (mode_left % 3 != 0);
                end
            endcase
        end
    end

    // Idle tick at target, set request during a move, and the first eased step
    // with the registers still at their reset values.
    task automatic test_reset_defaults();
        send_request(esmg_pkg::CMD_TICK, 8'd0);      // idle at target zero
        send_request(esmg_pkg::CMD_SET, 8'd255);
        send_request(esmg_pkg::CMD_TICK, 8'd0);      // start the move: step zero
        send_request(esmg_pkg::CMD_SET, 8'd0);       // the latched end position must stay
        send_request(esmg_pkg::CMD_TICK, 8'hFF);     // step 1 of 50
        wait_for_outputs();
    endtask

    // Lower motion_steps under a move in progress: the next tick lands on target.
    task automatic test_lowered_steps();
        write_reg(esmg_pkg::CFG_MOTION_STEPS, 16'd1);
        send_request(esmg_pkg::CMD_TICK, 8'd0);
        send_request(esmg_pkg::CMD_TICK, 8'h5A);     // desired is zero now: start back down
        wait_for_outputs();
    endtask

    // Zero motion_steps ends the move on its first advancing tick.
    task automatic test_zero_steps();
        write_reg(esmg_pkg::CFG_MOTION_STEPS, 16'd0);
        send_request(esmg_pkg::CMD_TICK, 8'd0);
        wait_for_outputs();
    endtask

    // Full-scale gain: the calibrated target saturates; then a short full move.
    task automatic test_gain_saturation();
        write_reg(esmg_pkg::CFG_CAL_GAIN, 16'hFFFF);
        write_reg(esmg_pkg::CFG_MOTION_STEPS, 16'd4);
        send_request(esmg_pkg::CMD_SET, 8'd20);
        repeat (6) send_request(esmg_pkg::CMD_TICK, 8'd0);
        wait_for_outputs();
    endtask

    // Zero gain pulls every target to zero; tick payload must be ignored.
    task automatic test_zero_gain();
        write_reg(esmg_pkg::CFG_CAL_GAIN, 16'd0);
        repeat (5) send_request(esmg_pkg::CMD_TICK, 8'hFF);
        send_request(esmg_pkg::CMD_SET, 8'hAA);
        send_request(esmg_pkg::CMD_SET, 8'h55);
        wait_for_outputs();
    endtask

    // Hold off the receiver for a long stretch while requests keep coming,
    // then pause the sender until everything has drained.
    task automatic test_backpressure();
        write_reg(esmg_pkg::CFG_CAL_GAIN, 16'd4096);
        write_reg(esmg_pkg::CFG_MOTION_STEPS, 16'd6);
        hold_req++;
        send_request(esmg_pkg::CMD_SET, pos_t'($urandom_range(0, 255)));
        repeat (9) send_request(esmg_pkg::CMD_TICK, pos_t'($urandom_range(0, 255)));
        send_request(esmg_pkg::CMD_SET, pos_t'($urandom_range(0, 255)));
        repeat (9) send_request(esmg_pkg::CMD_TICK, pos_t'($urandom_range(0, 255)));
        wait_for_outputs();
    endtask

    // Random registers per phase, then set-and-tick move sequences with some noise.
    task automatic test_random_motion();
        int unsigned seqs;
        int unsigned ticks;
        int unsigned pick;
        gain_t       gain;
        steps_t      steps;
        pos_t        desired;
        while (requests_sent < RANDOM_REQUESTS) begin
            wait_for_outputs();
            pick = $urandom_range(0, 5);
            case (pick)
                0:       gain = 16'd4096;
                1:       gain = 16'd0;
                2:       gain = 16'hFFFF;
                3:       gain = gain_t'($urandom_range(0, 65535));
                default: gain = gain_t'($urandom_range(2048, 8192));
            endcase
            pick = $urandom_range(0, 19);
            if (pick < 14) begin
                steps = steps_t'($urandom_range(1, 12));
            end else if (pick < 18) begin
                steps = steps_t'($urandom_range(13, 64));
            end else if (pick == 18) begin
                steps = 8'd1;
            end else begin
                steps = 8'd255;
            end
            // write one register or both; leave a move unfinished now and then
            if ($urandom_range(0, 2) != 0) begin
                write_reg(esmg_pkg::CFG_CAL_GAIN, gain);
            end
            if ($urandom_range(0, 2) != 0 || ax_gain != gain) begin
                write_reg(esmg_pkg::CFG_MOTION_STEPS, {8'd0, steps});
            end
            seqs = (ax_steps > 64) ? 1 : $urandom_range(2, 5);
            repeat (seqs) begin
                pick = $urandom_range(0, 7);
                if (pick == 0) begin
                    desired = 8'd0;
                end else if (pick == 1) begin
                    desired = 8'd255;
                end else begin
                    desired = pos_t'($urandom_range(0, 255));
                end
                sender_pace();
                send_request(esmg_pkg::CMD_SET, desired);
                if ($urandom_range(0, 3) == 0) begin
                    ticks = $urandom_range(0, ax_steps);
                end else begin
                    ticks = ax_steps + $urandom_range(0, 3);
                end
                repeat (ticks) begin
                    sender_pace();
                    if ($urandom_range(0, 11) == 0) begin
                        send_request(esmg_pkg::CMD_SET, pos_t'($urandom_range(0, 255)));
                    end else begin
                        send_request(esmg_pkg::CMD_TICK, pos_t'($urandom_range(0, 255)));
                    end
                end
            end
        end
        wait_for_outputs();
    endtask

    // Main sequence: reset once, then each test in turn.
    initial begin
        ax_gain    = esmg_pkg::CAL_GAIN_RST;
        ax_steps   = esmg_pkg::MOTION_STEPS_RST;
        ax_desired = '0;
        ax_current = '0;
        ax_start   = '0;
        ax_end     = '0;
        ax_step    = '0;
        ax_moving  = 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_lowered_steps();
        test_zero_steps();
        test_gain_saturation();
        test_zero_gain();
        test_backpressure();
        test_random_motion();

        // let any stray result show up before judging
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (error_count == 0 && servo_out_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Hard stop if the run hangs.
    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/esmg_pkg.sv
hw/rtl/esmg_ctrl.sv
hw/rtl/esmg_dp.sv
hw/rtl/eased_servo_motion_generator_top.sv
hw/rtl/esmg_chk.sv
verif/tb_eased_servo_motion_generator_top.sv
